@@ sv/shabs_pkg.sv @@
// shared types, command struct and constant tables for the sha-256 byte stream hasher
package shabs_pkg;

  // request kinds on the input channel
  typedef enum logic {
    REQ_DATA   = 1'b0,
    REQ_FINISH = 1'b1
  } req_type_e;

  // source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    BYTE_DATA = 2'd0,
    BYTE_PAD  = 2'd1,
    BYTE_ZERO = 2'd2,
    BYTE_LEN  = 2'd3
  } byte_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic      shift_byte;
    byte_sel_e byte_sel;
    logic      load_vars;
    logic      do_round;
    logic [5:0] rnd;
    logic      fold;
    logic      load_out;
    logic      shift_out;
  } dp_cmd_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

@@ sv/shabs_if.sv @@
// request and response channel interfaces of the sha-256 byte stream hasher
interface shabs_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface shabs_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

@@ sv/sha256_byte_stream_hasher.sv @@
// sha-256 byte stream hasher top level
// a data byte shifts into the block buffer; the 64th byte of a block then
// starts a working-variable load, 64 rounds of the single round unit, hash fold
// a finish pads one byte per cycle, compresses one or two blocks, then
// drains eight digest words from an output line while new bytes are taken
// async active-low reset restores the initial hash, zero length, empty buffer
module sha256_byte_stream_hasher (
  input logic         clk_i,
  input logic         rst_ni,
  shabs_req_if.sink   req_i,
  shabs_rsp_if.source rsp_o
);

  shabs_pkg::dp_cmd_t cmd;
  logic               req_ready;
  logic               rsp_valid;
  logic [2:0]         word_index;
  logic               last_word;
  logic [31:0]        digest_word;

  shabs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_type_i   (req_i.req_type),
    .rsp_ready_i  (rsp_o.ready),
    .req_ready_o  (req_ready),
    .rsp_valid_o  (rsp_valid),
    .word_index_o (word_index),
    .last_word_o  (last_word),
    .cmd_o        (cmd)
  );

  shabs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (req_i.data_byte),
    .digest_word_o (digest_word)
  );

  assign req_i.ready       = req_ready;
  assign rsp_o.valid       = rsp_valid;
  assign rsp_o.digest_word = digest_word;
  assign rsp_o.word_index  = word_index;
  assign rsp_o.last_word   = last_word;

  // a finish request leaves intake closed while padding runs
  a_finish_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && req_i.req_type |=> !req_i.ready)
    else $error("intake open right after a finish request");

  // digest words come out in order without gaps in the index
  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.ready && !rsp_o.last_word |=>
      rsp_o.valid && (rsp_o.word_index == $past(rsp_o.word_index) + 3'd1))
    else $error("digest word index did not advance");

  // a new digest cannot follow the last word immediately
  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.ready && rsp_o.last_word |=> !rsp_o.valid)
    else $error("response still valid after the last digest word");

endmodule

@@ sv/shabs_dp.sv @@
// sha-256 datapath: block buffer and schedule window, round logic, hash and output words
module shabs_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shabs_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]        data_byte_i,
  output logic [31:0]       digest_word_o
);

  logic [511:0] blk_q;
  logic [63:0]  msg_bits_q;
  logic [31:0]  hash_q [8];
  logic [31:0]  var_q [8];
  logic [31:0]  out_q [8];

  logic [7:0]  byte_in;
  logic [31:0] w0, w1, w9, w14, w_new, sg0, sg1;
  logic [31:0] big0, big1, ch, maj, t1, t2;

  // byte source for the buffer
  always_comb begin
    case (cmd_i.byte_sel)
      shabs_pkg::BYTE_DATA: byte_in = data_byte_i;
      shabs_pkg::BYTE_PAD:  byte_in = shabs_pkg::PAD_BYTE;
      shabs_pkg::BYTE_ZERO: byte_in = 8'h00;
      shabs_pkg::BYTE_LEN:  byte_in = msg_bits_q[63:56];
      default:              byte_in = 8'h00;
    endcase
  end

  // message schedule over the sixteen-word window, word zero at the top
  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];
  assign sg0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
  assign sg1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
  assign w_new = w0 + sg0 + w9 + sg1;

  // one compression round
  assign big1 = {var_q[4][5:0], var_q[4][31:6]} ^ {var_q[4][10:0], var_q[4][31:11]} ^
                {var_q[4][24:0], var_q[4][31:25]};
  assign ch   = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
  assign t1   = var_q[7] + big1 + ch + shabs_pkg::ROUND_K[cmd_i.rnd] + w0;
  assign big0 = {var_q[0][1:0], var_q[0][31:2]} ^ {var_q[0][12:0], var_q[0][31:13]} ^
                {var_q[0][21:0], var_q[0][31:22]};
  assign maj  = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
  assign t2   = big0 + maj;

  // block buffer doubles as the schedule shift line
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_byte) begin
      blk_q <= {blk_q[503:0], byte_in};
    end else if (cmd_i.do_round) begin
      blk_q <= {blk_q[479:0], w_new};
    end
  end

  // message bit count, shifted out a byte at a time as the length field
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_bits_q <= 64'd0;
    end else if (cmd_i.shift_byte && cmd_i.byte_sel == shabs_pkg::BYTE_DATA) begin
      msg_bits_q <= msg_bits_q + 64'd8;
    end else if (cmd_i.shift_byte && cmd_i.byte_sel == shabs_pkg::BYTE_LEN) begin
      msg_bits_q <= {msg_bits_q[55:0], 8'h00};
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vars) begin
      var_q <= hash_q;
    end else if (cmd_i.do_round) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
    end
  end

  // chaining hash, restarted once the digest is copied out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= shabs_pkg::HASH_IV;
    end else if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= hash_q[i] + var_q[i];
      end
    end else if (cmd_i.load_out) begin
      hash_q <= shabs_pkg::HASH_IV;
    end
  end

  // digest output shift line
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= hash_q;
    end else if (cmd_i.shift_out) begin
      for (int i = 0; i < 7; i++) begin
        out_q[i] <= out_q[i+1];
      end
    end
  end

  assign digest_word_o = out_q[0];

endmodule

@@ sv/shabs_ctrl.sv @@
// sha-256 controller: intake, padding, round sequencing and digest drain
module shabs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_type_i,
  input  logic               rsp_ready_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o,
  output shabs_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  state_e     state_q;
  logic [5:0] fill_q;
  logic [5:0] rnd_q;
  logic       pad_act_q;
  logic       pad_first_q;
  logic       final_blk_q;
  logic       out_busy_q;
  logic [2:0] out_cnt_q;

  logic req_acc;
  logic rsp_acc;

  assign req_ready_o  = (state_q == ST_IDLE);
  assign req_acc      = req_valid_i && req_ready_o;
  assign rsp_valid_o  = out_busy_q;
  assign rsp_acc      = out_busy_q && rsp_ready_i;
  assign word_index_o = out_cnt_q;
  assign last_word_o  = (out_cnt_q == shabs_pkg::LAST_WORD_IDX);

  // datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_sel  = shabs_pkg::BYTE_DATA;
    cmd_o.rnd       = rnd_q;
    cmd_o.shift_out = rsp_acc;
    case (state_q)
      ST_IDLE: begin
        cmd_o.shift_byte = req_acc && (req_type_i == shabs_pkg::REQ_DATA);
      end
      ST_PAD: begin
        cmd_o.shift_byte = 1'b1;
        if (pad_first_q) begin
          cmd_o.byte_sel = shabs_pkg::BYTE_PAD;
        end else if (final_blk_q && fill_q >= shabs_pkg::LEN_POS) begin
          cmd_o.byte_sel = shabs_pkg::BYTE_LEN;
        end else begin
          cmd_o.byte_sel = shabs_pkg::BYTE_ZERO;
        end
      end
      ST_LOAD:  cmd_o.load_vars = 1'b1;
      ST_ROUND: cmd_o.do_round = 1'b1;
      ST_FOLD:  cmd_o.fold = 1'b1;
      ST_EMIT:  cmd_o.load_out = !out_busy_q;
      default: ;
    endcase
  end

  // state and registered control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= 6'd0;
      rnd_q       <= 6'd0;
      pad_act_q   <= 1'b0;
      pad_first_q <= 1'b0;
      final_blk_q <= 1'b0;
      out_busy_q  <= 1'b0;
      out_cnt_q   <= 3'd0;
    end else begin
      // digest drain runs beside everything else
      if (rsp_acc) begin
        out_cnt_q <= out_cnt_q + 3'd1;
        if (out_cnt_q == shabs_pkg::LAST_WORD_IDX) begin
          out_busy_q <= 1'b0;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            if (req_type_i == shabs_pkg::REQ_DATA) begin
              fill_q <= fill_q + 6'd1;
              if (fill_q == shabs_pkg::LAST_POS) begin
                state_q <= ST_LOAD;
              end
            end else begin
              pad_act_q   <= 1'b1;
              pad_first_q <= 1'b1;
              state_q     <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          fill_q      <= fill_q + 6'd1;
          pad_first_q <= 1'b0;
          // length fits behind the pad byte only if it lands below byte 56
          if (pad_first_q) begin
            final_blk_q <= (fill_q < shabs_pkg::LEN_POS);
          end
          if (fill_q == shabs_pkg::LAST_POS) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          rnd_q   <= 6'd0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == shabs_pkg::LAST_RND) begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          if (!pad_act_q) begin
            state_q <= ST_IDLE;
          end else if (final_blk_q) begin
            state_q <= ST_EMIT;
          end else begin
            final_blk_q <= 1'b1;
            state_q     <= ST_PAD;
          end
        end
        ST_EMIT: begin
          if (!out_busy_q) begin
            out_busy_q  <= 1'b1;
            out_cnt_q   <= 3'd0;
            pad_act_q   <= 1'b0;
            final_blk_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
